// ===== design/lnps_pkg.sv =====
// ----------------------------------------------------------------------------
// lnps_pkg: shared types and constants for the last-note priority stack
// Stack geometry, cell control word, controller states and result word.
// ----------------------------------------------------------------------------
package lnps_pkg;

  // stack geometry
  localparam int unsigned StackDepth = 16;
  localparam int unsigned NoteW      = 7;
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  localparam int unsigned IdxW       = $clog2(StackDepth);

  typedef logic [NoteW-1:0] note_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [IdxW-1:0]  idx_t;

  // result kinds
  localparam logic KindNote = 1'b0;
  localparam logic KindVel  = 1'b1;

  // per-cell operation, broadcast along the row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_BUBBLE,
    CELL_PUSH
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    note_t    note;
  } cell_ctrl_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SHIFT,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic  kind;
    note_t value;
  } result_t;

endpackage

// ===== design/lnps_if.sv =====
// ----------------------------------------------------------------------------
// lnps_if: valid/ready channels of the last-note priority stack
// One interface for note events in, one for result words out.
// ----------------------------------------------------------------------------
interface lnps_in_if;
  logic                valid;
  logic                ready;
  lnps_pkg::note_t     note_number;
  lnps_pkg::note_t     note_velocity;

  modport source (output valid, output note_number, output note_velocity, input ready);
  modport sink   (input valid, input note_number, input note_velocity, output ready);
endinterface

interface lnps_out_if;
  logic                valid;
  logic                ready;
  logic                out_kind;
  lnps_pkg::note_t     out_value;
  logic                out_last;

  modport source (output valid, output out_kind, output out_value, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_value, input out_last,
                  output ready);
endinterface

// ===== design/lnps_cell.sv =====
// ----------------------------------------------------------------------------
// lnps_cell: one entry of the held-note row
// Holds a note and a hole flag; matches, bubbles the hole outwards, or takes
// its inner neighbour's note on a push.
// ----------------------------------------------------------------------------
module lnps_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lnps_pkg::cell_ctrl_t ctrl_i,
  input  logic                 valid_i,
  input  logic                 tail_i,
  input  lnps_pkg::note_t      prev_entry_i,
  input  logic                 prev_hole_i,
  input  lnps_pkg::note_t      next_entry_i,
  output lnps_pkg::note_t      entry_o,
  output logic                 hole_o
);

  lnps_pkg::note_t entry_q, entry_d;
  logic            hole_q, hole_d;

  // cell operation
  always_comb begin
    entry_d = entry_q;
    hole_d  = hole_q;
    unique case (ctrl_i.op)
      lnps_pkg::CELL_HOLD: ;
      lnps_pkg::CELL_LOAD: begin
        hole_d = valid_i && (entry_q == ctrl_i.note);
      end
      lnps_pkg::CELL_BUBBLE: begin
        // hole moves one cell outwards, the outer note moves in
        if (hole_q && !tail_i) begin
          entry_d = next_entry_i;
        end
        hole_d = prev_hole_i | (hole_q & tail_i);
      end
      lnps_pkg::CELL_PUSH: begin
        entry_d = prev_entry_i;
      end
      default: ;
    endcase
  end

  // note store, no reset needed
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hole_q <= 1'b0;
    end else begin
      hole_q <= hole_d;
    end
  end

  assign entry_o = entry_q;
  assign hole_o  = hole_q;

endmodule

// ===== design/last_note_priority_stack.sv =====
// ----------------------------------------------------------------------------
// last_note_priority_stack: monophonic last-note priority note stack
//
//   channel  dir  payload                          word accepted when
//   in_i     in   note_number, note_velocity       valid && ready
//   out_o    out  out_kind, out_value, out_last    valid && ready
//
// Sequence: accept, match, StackDepth-1 hole-bubbling steps along the cell
// row, update, then one result word per cycle while out_o is ready; a note-on
// to a full stack returns to idle after the match and gives no word.
// One event at a time: in_i.ready is high only while idle.
// Reset clears the count, current note and hole flags; notes are unset.
// A stalled out_o holds its word; no new event is taken until all are sent.
// ----------------------------------------------------------------------------
module last_note_priority_stack (
  input  logic              clk_i,
  input  logic              rst_ni,
  lnps_in_if.sink           in_i,
  lnps_out_if.source        out_o
);

  localparam int unsigned Depth = lnps_pkg::StackDepth;

  lnps_pkg::state_e     state_q, state_d;
  lnps_pkg::cnt_t       count_q, count_d;
  lnps_pkg::note_t      current_q, current_d;
  lnps_pkg::note_t      note_q, note_d;
  lnps_pkg::note_t      vel_q, vel_d;
  lnps_pkg::idx_t       step_q, step_d;
  lnps_pkg::result_t    res0_q, res0_d, res1_q, res1_d;
  logic                 two_q, two_d;
  logic                 ridx_q, ridx_d;

  lnps_pkg::cell_ctrl_t cell_ctrl;
  lnps_pkg::note_t      cell_entry [Depth];
  logic [Depth-1:0]     cell_hole;
  logic [Depth-1:0]     cell_valid;

  logic                 in_hs, out_hs;
  logic                 note_on, full, found, upd_any, diff_top;
  lnps_pkg::cnt_t       cnt_rm;

  assign in_hs   = in_i.valid && in_i.ready;
  assign out_hs  = out_o.valid && out_o.ready;
  assign note_on = (vel_q != '0);
  assign full    = (count_q == lnps_pkg::CntW'(Depth));

  // after bubbling, a matched entry leaves its hole in the outermost cell
  assign found    = cell_hole[Depth-1];
  assign cnt_rm   = count_q - {{(lnps_pkg::CntW-1){1'b0}}, found};
  assign diff_top = (cell_entry[0] != current_q);
  assign upd_any  = note_on || (cnt_rm == '0) || (found && diff_top);

  // row of cells, newest note in cell 0
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam lnps_pkg::cnt_t Pos = lnps_pkg::CntW'(i);
    lnps_pkg::note_t prev_entry, next_entry;
    logic            prev_hole;

    assign cell_valid[i] = (Pos < count_q);

    if (i == 0) begin : g_head
      assign prev_entry = note_q;
      assign prev_hole  = 1'b0;
    end else begin : g_body
      assign prev_entry = cell_entry[i-1];
      assign prev_hole  = cell_hole[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = cell_entry[i+1];
    end

    lnps_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .valid_i      (cell_valid[i]),
      .tail_i       (i == Depth - 1),
      .prev_entry_i (prev_entry),
      .prev_hole_i  (prev_hole),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[i]),
      .hole_o       (cell_hole[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lnps_pkg::ST_IDLE:   if (in_hs) state_d = lnps_pkg::ST_MATCH;
      lnps_pkg::ST_MATCH:  state_d = (note_on && full) ? lnps_pkg::ST_IDLE
                                                       : lnps_pkg::ST_SHIFT;
      lnps_pkg::ST_SHIFT:  if (step_q == lnps_pkg::IdxW'(Depth - 2)) begin
                             state_d = lnps_pkg::ST_UPDATE;
                           end
      lnps_pkg::ST_UPDATE: state_d = upd_any ? lnps_pkg::ST_EMIT : lnps_pkg::ST_IDLE;
      lnps_pkg::ST_EMIT:   if (out_hs && (ridx_q || !two_q)) state_d = lnps_pkg::ST_IDLE;
      default:             state_d = lnps_pkg::ST_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    in_i.ready     = 1'b0;
    out_o.valid    = 1'b0;
    cell_ctrl.op   = lnps_pkg::CELL_HOLD;
    cell_ctrl.note = note_q;
    unique case (state_q)
      lnps_pkg::ST_IDLE:   in_i.ready = 1'b1;
      lnps_pkg::ST_MATCH:  if (!(note_on && full)) cell_ctrl.op = lnps_pkg::CELL_LOAD;
      lnps_pkg::ST_SHIFT:  cell_ctrl.op = lnps_pkg::CELL_BUBBLE;
      lnps_pkg::ST_UPDATE: if (note_on) cell_ctrl.op = lnps_pkg::CELL_PUSH;
      lnps_pkg::ST_EMIT:   out_o.valid = 1'b1;
      default: ;
    endcase
  end

  // result word
  assign out_o.out_kind  = ridx_q ? res1_q.kind : res0_q.kind;
  assign out_o.out_value = ridx_q ? res1_q.value : res0_q.value;
  assign out_o.out_last  = ridx_q || !two_q;

  // datapath
  always_comb begin
    count_d   = count_q;
    current_d = current_q;
    note_d    = note_q;
    vel_d     = vel_q;
    step_d    = step_q;
    res0_d    = res0_q;
    res1_d    = res1_q;
    two_d     = two_q;
    ridx_d    = ridx_q;
    case (state_q)
      lnps_pkg::ST_IDLE: begin
        if (in_hs) begin
          note_d = in_i.note_number;
          vel_d  = in_i.note_velocity;
        end
      end
      lnps_pkg::ST_MATCH: begin
        step_d = '0;
      end
      lnps_pkg::ST_SHIFT: begin
        step_d = step_q + lnps_pkg::IdxW'(1);
      end
      lnps_pkg::ST_UPDATE: begin
        ridx_d = 1'b0;
        two_d  = 1'b0;
        if (note_on) begin
          // push: emit the note, and the velocity when it is alone
          count_d      = cnt_rm + lnps_pkg::CntW'(1);
          current_d    = note_q;
          res0_d.kind  = lnps_pkg::KindNote;
          res0_d.value = note_q;
          res1_d.kind  = lnps_pkg::KindVel;
          res1_d.value = vel_q;
          two_d        = (cnt_rm == '0);
        end else begin
          count_d = cnt_rm;
          if (cnt_rm == '0) begin
            // gate closes
            res0_d.kind  = lnps_pkg::KindVel;
            res0_d.value = '0;
          end else if (found && diff_top) begin
            // fall back to the note now on top
            current_d    = cell_entry[0];
            res0_d.kind  = lnps_pkg::KindNote;
            res0_d.value = cell_entry[0];
          end
        end
      end
      lnps_pkg::ST_EMIT: begin
        if (out_hs) ridx_d = 1'b1;
      end
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    note_q <= note_d;
    vel_q  <= vel_d;
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lnps_pkg::ST_IDLE;
      count_q   <= '0;
      current_q <= '0;
      step_q    <= '0;
      two_q     <= 1'b0;
      ridx_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      current_q <= current_d;
      step_q    <= step_d;
      two_q     <= two_d;
      ridx_q    <= ridx_d;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lnps_pkg::CntW'(Depth))
    else $error("held count beyond stack depth");

  a_single_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_hole) <= 1)
    else $error("more than one matching cell");

  a_second_is_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && ridx_q |-> out_o.out_kind == lnps_pkg::KindVel && out_o.out_last)
    else $error("second word is not a closing velocity");

  a_gate_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.out_kind == lnps_pkg::KindVel && out_o.out_value != '0
      |-> count_q == lnps_pkg::CntW'(1))
    else $error("gate opened with more than one held note");

endmodule
